// ===== design/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants of the pressure pen tracker
// Event codes, register indexes and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  localparam int DATA_W     = 32;   // width of every arithmetic stage
  localparam int CFG_W      = 16;   // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 12;
  localparam int PRESSURE_W = 20;
  localparam int SCALE_SHIFT = 12;
  localparam int ROUND_ADD  = 2047;
  localparam int XY_FUZZ    = 16;
  localparam int CNT_W      = 5;    // counts up to DATA_W - 1

  typedef enum logic [1:0] {
    EV_IDLE    = 2'd0,
    EV_REJECT  = 2'd1,
    EV_TOUCH   = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLATE_OHMS   = 2'd0,
    REG_MAX_PRESSURE = 2'd1
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== design/touch_pressure_pen_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_pressure_pen_tracker: resistive touch pressure and pen state
// Computes (z2-z1)*x/z1*plate_ohms with a bit-serial sequencer and reports
// touch, release and rejected samples.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one request carries x, y, z1 and z2.
//   Result channel (out_valid / out_stall): exactly one result per request.
//   Configuration (cfg_we / cfg_index / cfg_wdata): plate_ohms at index 0,
//   max_pressure at index 1; write only while no request is in flight.
// Sequence
//   A request with a usable x and nonzero z1 runs through three bit-serial
//   loops: (z2-z1)*x, the restoring divide by z1 and the multiply by
//   plate_ohms, then a finish step that rounds and classifies. A request
//   with no pressure skips the loops and goes straight to the finish step.
//   One request is worked at a time; in_stall is low only while idle.
// Reset
//   rst_n (synchronous, active low) empties the sequencer and the result
//   register, sets the pen up and loads plate_ohms 400, max_pressure 600.
// Stall
//   The result register holds while out_stall is high; a new request may be
//   accepted meanwhile, and its result waits in the finish step until the
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_pressure_pen_tracker
  import tpt_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // input channel
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [SAMPLE_BITS-1:0]   in_x_meas,
  input  wire  [SAMPLE_BITS-1:0]   in_y_meas,
  input  wire  [SAMPLE_BITS-1:0]   in_z1_meas,
  input  wire  [SAMPLE_BITS-1:0]   in_z2_meas,
  // result channel
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [1:0]               out_event_kind,
  output logic                     out_down_edge,
  output logic [POS_W-1:0]         out_pos_x,
  output logic [POS_W-1:0]         out_pos_y,
  output logic [PRESSURE_W-1:0]    out_pressure,
  output logic                     out_keep_polling,
  // configuration
  input  wire                      cfg_we,
  input  wire  [CFG_IDX_W-1:0]     cfg_index,
  input  wire  [CFG_W-1:0]         cfg_wdata
);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
  localparam logic [CNT_W-1:0] MUL1_LAST = CNT_W'(SAMPLE_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DATA_W - 1);
  localparam logic [CNT_W-1:0] MUL2_LAST = CNT_W'(CFG_W - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0]      acc_r, acc_nxt;     // product accumulator
  logic [DATA_W-1:0]      opa_r, opa_nxt;     // multiplicand, then dividend/quotient
  logic [CFG_W-1:0]       opb_r, opb_nxt;     // multiplier bits, LSB first
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;     // divide remainder
  logic [SAMPLE_BITS-1:0] z1_r, z1_nxt;
  logic [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic [CFG_W-1:0]       plate_r, plate_nxt;
  logic [CFG_W-1:0]       max_r, max_nxt;
  logic                   pen_r, pen_nxt;

  logic                   out_valid_r, out_valid_nxt;
  event_kind_t            kind_r, kind_nxt;
  logic                   edge_r, edge_nxt;
  logic [POS_W-1:0]       posx_r, posx_nxt;
  logic [POS_W-1:0]       posy_r, posy_nxt;
  logic [PRESSURE_W-1:0]  pres_r, pres_nxt;
  logic                   poll_r, poll_nxt;

  logic                   in_take;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] x_filt;
  logic [DATA_W-1:0]      acc_step;
  logic [SAMPLE_BITS:0]   trial;
  logic                   q_bit;
  logic [DATA_W-1:0]      rounded;
  logic [PRESSURE_W-1:0]  p_val;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // full scale and near-zero x carry no position
  assign x_filt = ((in_x_meas == FULL_SCALE) ||
                   (in_x_meas < SAMPLE_BITS'(XY_FUZZ))) ? '0 : in_x_meas;

  // shared shift-add step of both multiplies
  assign acc_step = opb_r[0] ? (acc_r + opa_r) : acc_r;

  // restoring divide step: bring down one dividend bit
  assign trial = {rem_r, opa_r[DATA_W-1]};
  assign q_bit = (trial >= {1'b0, z1_r});

  assign rounded = acc_r + DATA_W'(ROUND_ADD);
  assign p_val   = rounded[DATA_W-1:SCALE_SHIFT];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    rem_nxt       = rem_r;
    z1_nxt        = z1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    plate_nxt     = plate_r;
    max_nxt       = max_r;
    pen_nxt       = pen_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    edge_nxt      = edge_r;
    posx_nxt      = posx_r;
    posy_nxt      = posy_r;
    pres_nxt      = pres_r;
    poll_nxt      = poll_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PLATE_OHMS:   plate_nxt = cfg_wdata;
        REG_MAX_PRESSURE: max_nxt   = cfg_wdata;
        default: ;  // drop writes to unknown registers
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          x_nxt   = in_x_meas;
          y_nxt   = in_y_meas;
          z1_nxt  = in_z1_meas;
          acc_nxt = '0;
          if ((x_filt == '0) || (in_z1_meas == '0)) begin
            // no pressure: a zero accumulator rounds to zero
            state_nxt = ST_DONE;
          end else begin
            opa_nxt   = DATA_W'(in_z2_meas) - DATA_W'(in_z1_meas);
            opb_nxt   = CFG_W'(x_filt);
            cnt_nxt   = MUL1_LAST;
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        acc_nxt = acc_step;
        opa_nxt = {opa_r[DATA_W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[CFG_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          opa_nxt   = acc_step;
          rem_nxt   = '0;
          cnt_nxt   = DIV_LAST;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? SAMPLE_BITS'(trial - {1'b0, z1_r}) : trial[SAMPLE_BITS-1:0];
        opa_nxt = {opa_r[DATA_W-2:0], q_bit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          acc_nxt   = '0;
          opb_nxt   = plate_r;
          cnt_nxt   = MUL2_LAST;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        acc_nxt = acc_step;
        opa_nxt = {opa_r[DATA_W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[CFG_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = EV_IDLE;
          edge_nxt      = 1'b0;
          posx_nxt      = '0;
          posy_nxt      = '0;
          pres_nxt      = '0;
          if (p_val > PRESSURE_W'(max_r)) begin
            kind_nxt = EV_REJECT;
            pres_nxt = p_val;
          end else if (p_val != '0) begin
            kind_nxt = EV_TOUCH;
            edge_nxt = !pen_r;
            pen_nxt  = 1'b1;
            posx_nxt = POS_W'(x_r);
            posy_nxt = POS_W'(y_r);
            pres_nxt = p_val;
          end else if (pen_r) begin
            kind_nxt = EV_RELEASE;
            pen_nxt  = 1'b0;
          end
          poll_nxt  = (p_val > PRESSURE_W'(max_r)) ? pen_r : (p_val != '0);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pen_r       <= 1'b0;
      plate_r     <= CFG_W'(400);
      max_r       <= CFG_W'(600);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pen_r       <= pen_nxt;
      plate_r     <= plate_nxt;
      max_r       <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    rem_r  <= rem_nxt;
    z1_r   <= z1_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    kind_r <= kind_nxt;
    edge_r <= edge_nxt;
    posx_r <= posx_nxt;
    posy_r <= posy_nxt;
    pres_r <= pres_nxt;
    poll_r <= poll_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_down_edge    = edge_r;
  assign out_pos_x        = posx_r;
  assign out_pos_y        = posy_r;
  assign out_pressure     = pres_r;
  assign out_keep_polling = poll_r;

endmodule

`default_nettype wire

// ===== design/tpt_checker.sv =====
// ----------------------------------------------------------------------------
// tpt_checker: port-level checks of the pressure pen tracker
// Watches both channels and the consistency of each reported result.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_checker
  import tpt_pkg::*;
(
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire [1:0]              out_event_kind,
  input wire                    out_down_edge,
  input wire [PRESSURE_W-1:0]   out_pressure,
  input wire                    out_keep_polling
);

  // an accepted request keeps the input side busy while it is worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a request");

  // a waiting result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pressure)
                               && $stable(out_event_kind))
    else $error("stalled result changed");

  // a touch leaves the pen down and carries pressure
  a_touch_pen_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_TOUCH) |-> out_keep_polling
                                                 && (out_pressure != '0))
    else $error("touch result without pen-down or pressure");

  // a release lifts the pen and reports nothing else
  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_RELEASE) |-> !out_keep_polling
      && (out_pressure == '0) && !out_down_edge)
    else $error("release result with leftover fields");

  // a down edge only comes with a touch
  a_edge_on_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_down_edge |-> (out_event_kind == EV_TOUCH))
    else $error("down edge outside a touch result");

endmodule

bind touch_pressure_pen_tracker tpt_checker u_tpt_checker (.*);

`default_nettype wire

// ===== test/tb_touch_pressure_pen_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_pressure_pen_tracker: self-checking bench for the pen tracker
// Drives touch samples through the valid/stall request channel and scores
// every result against a cycle-free predictor of the pressure math and the
// pen state. Directed corner samples and register extremes run first. Three
// random phases follow: sender idling with heavy receiver stalling, then the
// two swapped, then full rate.
// ----------------------------------------------------------------------------

module tb_touch_pressure_pen_tracker;
  import tpt_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
  // indexes that decode to no register; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [CFG_W-1:0] PLATE_OHMS_RESET   = 16'd400;
  localparam logic [CFG_W-1:0] MAX_PRESSURE_RESET = 16'd600;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 70;   // past the worst-case latency
  localparam int MAX_REPORTED  = 10;

  typedef struct packed {
    event_kind_t             kind;
    logic                    down_edge;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [PRESSURE_W-1:0]   pressure;
    logic                    keep_polling;
  } pen_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_x_meas = '0;
  logic [SAMPLE_BITS-1:0] in_y_meas = '0;
  logic [SAMPLE_BITS-1:0] in_z1_meas = '0;
  logic [SAMPLE_BITS-1:0] in_z2_meas = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_event_kind;
  logic                   out_down_edge;
  logic [POS_W-1:0]       out_pos_x;
  logic [POS_W-1:0]       out_pos_y;
  logic [PRESSURE_W-1:0]  out_pressure;
  logic                   out_keep_polling;

  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // predictor state: register shadows and the pen flag
  logic [CFG_W-1:0] plate_ohms_model = PLATE_OHMS_RESET;
  logic [CFG_W-1:0] max_pressure_model = MAX_PRESSURE_RESET;
  logic             pen_down_model = 1'b0;

  // reports owed by the block, oldest first
  pen_report_t expected_reports[$];

  int send_idle_pct = 0;    // chance per cycle that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int mismatch_count = 0;
  int cycle_count = 0;

  touch_pressure_pen_tracker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_meas        (in_x_meas),
    .in_y_meas        (in_y_meas),
    .in_z1_meas       (in_z1_meas),
    .in_z2_meas       (in_z2_meas),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_down_edge    (out_down_edge),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pressure     (out_pressure),
    .out_keep_polling (out_keep_polling),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run; the limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Randomize backpressure on the result channel every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Pressure resistance; every stage wraps at DATA_W bits like the hardware.
  function automatic logic [DATA_W-1:0] calc_pressure(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [SAMPLE_BITS-1:0] z1,
    input logic [SAMPLE_BITS-1:0] z2
  );
    logic [DATA_W-1:0] x_w;
    logic [DATA_W-1:0] z1_w;
    logic [DATA_W-1:0] z2_w;
    logic [DATA_W-1:0] plate_w;
    logic [DATA_W-1:0] acc;
    x_w = DATA_W'(x);
    z1_w = DATA_W'(z1);
    z2_w = DATA_W'(z2);
    plate_w = DATA_W'(plate_ohms_model);
    // drop a pinned or noise-floor x reading
    if (x == FULL_SCALE || x_w < XY_FUZZ)
      x_w = '0;
    if (x_w == 0 || z1_w == 0)
      return '0;
    acc = z2_w - z1_w;          // wraps when z2 < z1
    acc = acc * x_w;
    acc = acc / z1_w;
    acc = acc * plate_w;
    acc = acc + DATA_W'(ROUND_ADD);
    acc = acc >> SCALE_SHIFT;
    return acc;
  endfunction

  // Classify one sample and advance the pen flag.
  function automatic pen_report_t predict_report(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [SAMPLE_BITS-1:0] y,
    input logic [SAMPLE_BITS-1:0] z1,
    input logic [SAMPLE_BITS-1:0] z2
  );
    logic [DATA_W-1:0] p;
    pen_report_t r;
    p = calc_pressure(x, z1, z2);
    r = '0;
    r.kind = EV_IDLE;
    if (p > max_pressure_model) begin
      // unstable: report the value, leave the pen alone
      r.kind = EV_REJECT;
      r.pressure = p[PRESSURE_W-1:0];
    end else if (p != 0) begin
      r.kind = EV_TOUCH;
      r.down_edge = !pen_down_model;
      pen_down_model = 1'b1;
      r.pos_x = x;
      r.pos_y = y;
      r.pressure = p[PRESSURE_W-1:0];
    end else if (pen_down_model) begin
      r.kind = EV_RELEASE;
      pen_down_model = 1'b0;
    end
    r.keep_polling = pen_down_model;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch on %s: expected %0d, actual %0d", field, want, got);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      note_mismatch(field, want, got);
  endtask

  // Score each result as it leaves the block against the oldest report owed.
  always @(posedge clk) begin : score_reports
    pen_report_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("unexpected result: kind %0d pressure %0d", out_event_kind,
                   out_pressure);
      end else begin
        want = expected_reports.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(out_event_kind));
        check_field("down_edge", 32'(want.down_edge), 32'(out_down_edge));
        check_field("pos_x", 32'(want.pos_x), 32'(out_pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(out_pos_y));
        check_field("pressure", 32'(want.pressure), 32'(out_pressure));
        check_field("keep_polling", 32'(want.keep_polling),
                    32'(out_keep_polling));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; each starts and ends on a rising edge
  // --------------------------------------------------------------------------

  // Offer one sample and hold it until the block takes the request.
  task automatic send_sample(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [SAMPLE_BITS-1:0] y,
    input logic [SAMPLE_BITS-1:0] z1,
    input logic [SAMPLE_BITS-1:0] z2
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_meas <= x;
    in_y_meas <= y;
    in_z1_meas <= z1;
    in_z2_meas <= z2;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    expected_reports.push_back(predict_report(x, y, z1, z2));
  endtask

  // Drop valid and hold off until every owed report has come back.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PLATE_OHMS:   plate_ohms_model = data;
      REG_MAX_PRESSURE: max_pressure_model = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Build one random sample: mostly plausible presses, then lifts, reversed
  // plates and raw noise.
  task automatic make_sample(
    output logic [SAMPLE_BITS-1:0] x,
    output logic [SAMPLE_BITS-1:0] y,
    output logic [SAMPLE_BITS-1:0] z1,
    output logic [SAMPLE_BITS-1:0] z2
  );
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    x = SAMPLE_BITS'($urandom_range(XY_FUZZ, FULL_SCALE - 1));
    y = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
    z1 = SAMPLE_BITS'($urandom_range(1, FULL_SCALE));
    z2 = z1;
    if (pick < 55) begin
      // press: z2 above z1 by up to twice z1
      span = FULL_SCALE - z1;
      if (span > 2 * z1)
        span = 2 * z1;
      z2 = SAMPLE_BITS'(z1 + $urandom_range(0, span));
    end else if (pick < 70) begin
      // lift: something forces zero pressure
      case ($urandom_range(0, 3))
        0: x = SAMPLE_BITS'($urandom_range(0, XY_FUZZ - 1));
        1: begin
          z1 = '0;
          z2 = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
        end
        2: z2 = z1;
        default: begin
          x = FULL_SCALE;
          z2 = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
        end
      endcase
    end else if (pick < 82) begin
      z2 = SAMPLE_BITS'($urandom_range(0, z1 - 1));
    end else begin
      x = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
      z1 = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
      z2 = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner samples under the reset register values.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 40;
    send_sample(12'd0, 12'd0, 12'd0, 12'd0);               // idle, all zero
    send_sample(FULL_SCALE, 12'd100, 12'd500, 12'd900);    // pinned x
    send_sample(12'd15, 12'd100, 12'd500, 12'd900);        // x under fuzz
    send_sample(12'd2000, 12'd1500, 12'd0, 12'd900);       // no z1
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1200);   // touch, down edge
    send_sample(12'd16, 12'd0, 12'd1, 12'd2);              // smallest x, y zero
    send_sample(12'd4094, FULL_SCALE, 12'd2000, 12'd4000); // at the limit
    send_sample(12'd3000, 12'd700, 12'd100, 12'd3000);     // reject, pen held
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1000);   // release
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1000);   // zero while up
    send_sample(12'd2000, 12'd1500, 12'd3000, 12'd100);    // z2 below z1
    send_sample(12'd4094, 12'd0, 12'd1, FULL_SCALE);       // plate_ohms product wraps
    send_sample(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
    send_sample(12'd1000, 12'd2000, FULL_SCALE, FULL_SCALE);
    send_sample(12'd2048, 12'd2048, 12'd1024, 12'd1100);   // touch again
    send_sample(12'd0, 12'd3000, 12'd1000, 12'd2000);      // lift by x
    drain_reports();
  endtask

  // Walk both registers through their extremes and poke the unused indexes.
  task automatic test_register_extremes();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    set_register(REG_PLATE_OHMS, 16'h0000);   // every pressure collapses to 0
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1200);
    send_sample(12'd4094, 12'd4094, 12'd1, FULL_SCALE);
    drain_reports();
    set_register(REG_PLATE_OHMS, 16'hFFFF);
    set_register(REG_MAX_PRESSURE, 16'h0000); // every nonzero pressure rejected
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1200);
    send_sample(12'd0, 12'd0, 12'd0, 12'd0);
    drain_reports();
    set_register(REG_MAX_PRESSURE, 16'hFFFF);
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1200);
    send_sample(12'd1000, 12'd1000, 12'd1, FULL_SCALE);
    drain_reports();
    set_register(REG_SPARE_LO, 16'hFFFF);     // must leave both registers
    set_register(REG_SPARE_HI, 16'h0000);
    send_sample(12'd2000, 12'd1500, 12'd1000, 12'd1200);
    drain_reports();
    set_register(REG_PLATE_OHMS, PLATE_OHMS_RESET);
    set_register(REG_MAX_PRESSURE, MAX_PRESSURE_RESET);
    send_sample(12'd0, 12'd0, 12'd0, 12'd0);
    drain_reports();
  endtask

  // One random phase: load the registers, then stream samples, pausing the
  // sender halfway until every owed report has come back.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct,
                                     input logic [CFG_W-1:0] plate,
                                     input logic [CFG_W-1:0] limit);
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] z1;
    logic [SAMPLE_BITS-1:0] z2;
    int i;
    drain_reports();
    set_register(REG_PLATE_OHMS, plate);
    set_register(REG_MAX_PRESSURE, limit);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      make_sample(x, y, z1, z2);
      send_sample(x, y, z1, z2);
      if (i == count / 2)
        drain_reports();
    end
  endtask

  initial begin
    // hold reset, then release it once for good
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_random_traffic(300, 26, 82, PLATE_OHMS_RESET, MAX_PRESSURE_RESET);
    test_random_traffic(300, 82, 26, 16'($urandom_range(100, 2000)),
                        16'($urandom_range(200, 4000)));
    test_random_traffic(300, 0, 0, 16'hFFFF, 16'hFFFF);

    // flush the last reports and give the block time to show a stray one
    in_valid <= 1'b0;
    while (expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
